// File: hdl/uart_pkg.sv
`timescale 1ns / 1ps

package uart_pkg;

    localparam logic [7:0] DIVIDER_RESET = 8'd103;
    localparam logic [7:0] RX_MSB_SET    = 8'h80;
    localparam logic [2:0] BIT_LAST      = 3'd7;

    typedef enum logic [1:0] {
        TX_IDLE,
        TX_DATA,
        TX_STOP,
        TX_FINISH
    } tx_state_t;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_START,
        RX_DATA,
        RX_STOP
    } rx_state_t;

endpackage

// File: hdl/uart_ifs.sv
`timescale 1ns / 1ps

// one timer tick request
interface uart_tick_if;
    logic       valid;
    logic       ready;
    logic       rx_line;
    logic       tx_write;
    logic [7:0] tx_byte;
    logic       rx_pop;

    modport source (output valid, rx_line, tx_write, tx_byte, rx_pop, input ready);
    modport sink   (input valid, rx_line, tx_write, tx_byte, rx_pop, output ready);
endinterface

// status request returned for every tick
interface uart_status_if;
    logic       valid;
    logic       ready;
    logic       tx_line;
    logic       tx_hold_empty;
    logic       tx_all_done;
    logic [7:0] rx_byte;
    logic       rx_byte_valid;
    logic       rx_fifo_empty;
    logic       rx_overflow;

    modport source (output valid, tx_line, tx_hold_empty, tx_all_done, rx_byte,
                    rx_byte_valid, rx_fifo_empty, rx_overflow, input ready);
    modport sink   (input valid, tx_line, tx_hold_empty, tx_all_done, rx_byte,
                    rx_byte_valid, rx_fifo_empty, rx_overflow, output ready);
endinterface

// File: hdl/uart_8n1_transceiver_rx_fifo.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Payload
// tick      in   valid/ready   rx_line, tx_write, tx_byte[7:0], rx_pop
// status    out  valid/ready   tx_line, tx_hold_empty, tx_all_done, rx_byte[7:0],
//                              rx_byte_valid, rx_fifo_empty, rx_overflow
// cfg       in   write enable  bit_divider_wdata[7:0]
//
// One tick request per clock unless stalled, one status request per tick,
// registered into the status register on acceptance; the whole tick update is one
// pass of logic from the state registers to themselves and to the status register.
// The status register frees the input side: a tick is taken while the last
// status is taken in the same cycle; only a held, untaken status stalls tick.
// Reset (rst_n, async low) idles both machines, empties the FIFO and loads
// the divider with 103. No clearing pass: FIFO entries are read only once
// written. The FIFO read port is registered straight into rx_byte.

module uart_8n1_transceiver_rx_fifo #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    uart_tick_if.sink           tick,
    uart_status_if.source       status,
    input  logic                bit_divider_we,
    input  logic [7:0]          bit_divider_wdata
);
    import uart_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    // ---------------- state ----------------
    logic [7:0]    bit_divider_reg;
    logic [7:0]    tick_count_reg, tick_count_next;

    tx_state_t     tx_state_reg, tx_state_next;
    logic [2:0]    tx_bit_reg, tx_bit_next;
    logic [7:0]    tx_shift_reg, tx_shift_next;
    logic [7:0]    tx_hold_reg, tx_hold_next;
    logic          tx_hold_free_reg, tx_hold_free_next;
    logic          tx_done_reg, tx_done_next;
    logic          tx_pin_reg, tx_pin_next;

    rx_state_t     rx_state_reg, rx_state_next, rx_mid;
    logic [2:0]    rx_bit_reg, rx_bit_next;
    logic [7:0]    rx_shift_reg, rx_shift_next;
    logic [7:0]    rx_sample_reg, rx_sample_next;
    logic          rx_prev_reg;

    logic [7:0]    fifo_mem [FIFO_DEPTH];
    logic [AW-1:0] fifo_head_reg, fifo_head_next;
    logic [AW-1:0] fifo_tail_reg, fifo_tail_next;
    logic [CW-1:0] fifo_count_reg, fifo_count_next, fifo_count_mid;

    // status register
    logic          out_valid_reg;
    logic          out_tx_line_reg, out_hold_empty_reg, out_all_done_reg;
    logic [7:0]    out_rx_byte_reg;
    logic          out_rx_valid_reg, out_fifo_empty_reg, out_overflow_reg;

    // ---------------- control ----------------
    logic       acc, wrap, rx_hit, rx_fall;
    logic       push, push_ok, pop_ok, overflow;
    logic [8:0] half_sum;

    assign tick.ready = !out_valid_reg || status.ready;
    assign acc        = tick.valid && tick.ready;

    // counters above a lowered divider also count as the wrap tick
    assign wrap   = tick_count_reg >= bit_divider_reg;
    // a sample point beyond the divider falls back to the wrap tick
    assign rx_hit = (rx_state_reg != RX_IDLE) &&
                    ((tick_count_reg == rx_sample_reg) ||
                     (wrap && (rx_sample_reg > bit_divider_reg)));

    // receiver next state: sample first, then start-edge detection
    always_comb
    begin
        rx_mid = rx_state_reg;
        if (rx_hit)
        begin
            case (rx_state_reg)
                RX_START: rx_mid = tick.rx_line ? RX_IDLE : RX_DATA;
                RX_DATA:  rx_mid = (rx_bit_reg == BIT_LAST) ? RX_STOP : RX_DATA;
                RX_STOP:  rx_mid = RX_IDLE;
                default:  rx_mid = RX_IDLE;
            endcase
        end
        rx_fall       = (rx_mid == RX_IDLE) && rx_prev_reg && !tick.rx_line;
        rx_state_next = rx_fall ? RX_START : rx_mid;
    end

    // receiver datapath
    always_comb
    begin
        rx_bit_next    = rx_bit_reg;
        rx_shift_next  = rx_shift_reg;
        rx_sample_next = rx_sample_reg;
        push           = 1'b0;
        if (rx_hit)
        begin
            case (rx_state_reg)
                RX_START: rx_bit_next = '0;
                RX_DATA:
                begin
                    rx_shift_next = (rx_shift_reg >> 1) | (tick.rx_line ? RX_MSB_SET : 8'h00);
                    rx_bit_next   = rx_bit_reg + 3'd1;
                end
                RX_STOP:  push = tick.rx_line;
                default:  push = 1'b0;
            endcase
        end
        // half a bit ahead, kept at 9 bits and folded back once
        half_sum = {1'b0, tick_count_reg} + {2'b00, bit_divider_reg[7:1]};
        if (half_sum >= {1'b0, bit_divider_reg})
        begin
            half_sum = half_sum - {1'b0, bit_divider_reg};
        end
        if (half_sum > {1'b0, bit_divider_reg})
        begin
            half_sum = '0;
        end
        if (rx_fall)
        begin
            rx_sample_next = half_sum[7:0];
        end
    end

    // transmitter next state, steps on the wrap tick only
    always_comb
    begin
        tx_state_next = tx_state_reg;
        if (wrap)
        begin
            case (tx_state_reg)
                TX_IDLE:   tx_state_next = tx_hold_free_reg ? TX_IDLE : TX_DATA;
                TX_DATA:   tx_state_next = (tx_bit_reg == BIT_LAST) ? TX_STOP : TX_DATA;
                TX_STOP:   tx_state_next = TX_FINISH;
                TX_FINISH: tx_state_next = TX_IDLE;
                default:   tx_state_next = TX_IDLE;
            endcase
        end
    end

    // transmitter datapath and holding register
    always_comb
    begin
        tx_bit_next       = tx_bit_reg;
        tx_shift_next     = tx_shift_reg;
        tx_hold_next      = tx_hold_reg;
        tx_hold_free_next = tx_hold_free_reg;
        tx_done_next      = tx_done_reg;
        tx_pin_next       = tx_pin_reg;
        if (wrap)
        begin
            case (tx_state_reg)
                TX_IDLE:
                begin
                    if (!tx_hold_free_reg)
                    begin
                        tx_pin_next       = 1'b0;
                        tx_shift_next     = tx_hold_reg;
                        tx_bit_next       = '0;
                        tx_hold_free_next = 1'b1;
                        tx_done_next      = 1'b0;
                    end
                end
                TX_DATA:
                begin
                    tx_pin_next   = tx_shift_reg[0];
                    tx_shift_next = tx_shift_reg >> 1;
                    tx_bit_next   = tx_bit_reg + 3'd1;
                end
                TX_STOP:   tx_pin_next  = 1'b1;
                TX_FINISH: tx_done_next = 1'b1;
                default:   tx_done_next = 1'b1;
            endcase
        end
        // load after the step, so a byte moved out frees the slot this tick
        if (tick.tx_write && tx_hold_free_next)
        begin
            tx_hold_next      = tick.tx_byte;
            tx_hold_free_next = 1'b0;
        end
    end

    assign tick_count_next = wrap ? 8'd0 : tick_count_reg + 8'd1;

    // FIFO: pop before push
    always_comb
    begin
        pop_ok         = tick.rx_pop && (fifo_count_reg != '0);
        fifo_head_next = fifo_head_reg;
        fifo_tail_next = fifo_tail_reg;
        fifo_count_mid = fifo_count_reg;
        if (pop_ok)
        begin
            fifo_head_next = (fifo_head_reg == LAST_IDX) ? '0 : fifo_head_reg + 1'b1;
            fifo_count_mid = fifo_count_reg - 1'b1;
        end
        push_ok  = push && (fifo_count_mid != FULL_CNT);
        overflow = push && !push_ok;
        fifo_count_next = fifo_count_mid;
        if (push_ok)
        begin
            fifo_tail_next  = (fifo_tail_reg == LAST_IDX) ? '0 : fifo_tail_reg + 1'b1;
            fifo_count_next = fifo_count_mid + 1'b1;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_divider_reg <= DIVIDER_RESET;
        end
        else if (bit_divider_we)
        begin
            bit_divider_reg <= bit_divider_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            tx_state_reg     <= TX_IDLE;
            tx_bit_reg       <= '0;
            tx_shift_reg     <= '0;
            tx_hold_reg      <= '0;
            tx_hold_free_reg <= 1'b1;
            tx_done_reg      <= 1'b1;
            tx_pin_reg       <= 1'b1;
            rx_state_reg     <= RX_IDLE;
            rx_bit_reg       <= '0;
            rx_shift_reg     <= '0;
            rx_sample_reg    <= '0;
            rx_prev_reg      <= 1'b1;
            fifo_head_reg    <= '0;
            fifo_tail_reg    <= '0;
            fifo_count_reg   <= '0;
        end
        else if (acc)
        begin
            tick_count_reg   <= tick_count_next;
            tx_state_reg     <= tx_state_next;
            tx_bit_reg       <= tx_bit_next;
            tx_shift_reg     <= tx_shift_next;
            tx_hold_reg      <= tx_hold_next;
            tx_hold_free_reg <= tx_hold_free_next;
            tx_done_reg      <= tx_done_next;
            tx_pin_reg       <= tx_pin_next;
            rx_state_reg     <= rx_state_next;
            rx_bit_reg       <= rx_bit_next;
            rx_shift_reg     <= rx_shift_next;
            rx_sample_reg    <= rx_sample_next;
            rx_prev_reg      <= tick.rx_line;
            fifo_head_reg    <= fifo_head_next;
            fifo_tail_reg    <= fifo_tail_next;
            fifo_count_reg   <= fifo_count_next;
        end
    end

    // FIFO storage; read data lands directly in the status register
    always_ff @(posedge clk)
    begin
        if (acc && push_ok)
        begin
            fifo_mem[fifo_tail_reg] <= rx_shift_reg;
        end
        if (acc)
        begin
            out_rx_byte_reg <= pop_ok ? fifo_mem[fifo_head_reg] : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            out_tx_line_reg    <= tx_pin_next;
            out_hold_empty_reg <= tx_hold_free_next;
            out_all_done_reg   <= tx_done_next;
            out_rx_valid_reg   <= pop_ok;
            out_fifo_empty_reg <= (fifo_count_next == '0);
            out_overflow_reg   <= overflow;
        end
    end

    assign status.valid         = out_valid_reg;
    assign status.tx_line       = out_tx_line_reg;
    assign status.tx_hold_empty = out_hold_empty_reg;
    assign status.tx_all_done   = out_all_done_reg;
    assign status.rx_byte       = out_rx_byte_reg;
    assign status.rx_byte_valid = out_rx_valid_reg;
    assign status.rx_fifo_empty = out_fifo_empty_reg;
    assign status.rx_overflow   = out_overflow_reg;

    // ---------------- assertions ----------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= FULL_CNT)
        else $error("FIFO count beyond depth");

    a_ptrs_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_count_reg == '0 || fifo_count_reg == FULL_CNT) |->
            fifo_head_reg == fifo_tail_reg)
        else $error("FIFO pointers disagree with count");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_overflow_reg) |-> fifo_count_reg == FULL_CNT)
        else $error("overflow flagged with room in FIFO");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_fifo_empty_reg == (fifo_count_reg == '0)))
        else $error("empty flag disagrees with FIFO count");

    a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && wrap) |=> tick_count_reg == 8'd0)
        else $error("tick counter failed to wrap");

endmodule

// File: bench/uart_status_check.sv
`timescale 1ns / 1ps

// Watches both channels, keeps its own model of the transceiver and compares
// every status request with the one predicted for its tick.
module uart_status_check #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    uart_tick_if       tick,
    uart_status_if     status,
    input  logic       bit_divider_we,
    input  logic [7:0] bit_divider_wdata,
    output int         fail_count,
    output int         pending,
    output int         bytes_queued,
    output int         bytes_dropped
);
    import uart_pkg::*;

    typedef struct packed {
        logic       tx_line;
        logic       tx_hold_empty;
        logic       tx_all_done;
        logic [7:0] rx_byte;
        logic       rx_byte_valid;
        logic       rx_fifo_empty;
        logic       rx_overflow;
    } status_word_t;

    logic [7:0] divider;
    logic [7:0] tick_cnt;

    tx_state_t  tx_st;
    logic [2:0] tx_bit;
    logic [7:0] tx_shift;
    logic [7:0] tx_hold;
    logic       tx_hold_free;
    logic       tx_done;
    logic       tx_pin;

    rx_state_t  rx_st;
    logic [2:0] rx_bit;
    logic [7:0] rx_shift;
    logic [7:0] rx_sample_at;
    logic       rx_last_level;
    logic [7:0] rx_queue[$];

    status_word_t status_due[$];
    status_word_t seen;
    status_word_t want;

    // one timer tick: receiver sample, edge detect, transmitter, counter,
    // holding load, pop, push
    function automatic status_word_t advance_tick(input logic rx, input logic wr,
                                                  input logic [7:0] tx_data,
                                                  input logic pop);
        status_word_t r;
        logic [7:0]   t;
        logic         wrap;
        logic         push;
        logic [7:0]   push_byte;
        logic [8:0]   half;
        r         = '0;
        t         = tick_cnt;
        wrap      = (t >= divider);
        push      = 1'b0;
        push_byte = 8'h00;

        if (rx_st != RX_IDLE && (t == rx_sample_at || (wrap && rx_sample_at > divider)))
        begin
            case (rx_st)
                RX_START:
                begin
                    rx_st  = rx ? RX_IDLE : RX_DATA;
                    rx_bit = 3'd0;
                end
                RX_DATA:
                begin
                    rx_shift = (rx_shift >> 1) | (rx ? RX_MSB_SET : 8'h00);
                    if (rx_bit == BIT_LAST)
                        rx_st = RX_STOP;
                    else
                        rx_bit = rx_bit + 3'd1;
                end
                RX_STOP:
                begin
                    push      = rx;
                    push_byte = rx_shift;
                    rx_st     = RX_IDLE;
                end
                default:
                    rx_st = RX_IDLE;
            endcase
        end

        if (rx_st == RX_IDLE && rx_last_level && !rx)
        begin
            // half-bit offset kept at 9 bits, folded once, then clamped
            half = {1'b0, t} + {2'b00, divider[7:1]};
            if (half >= {1'b0, divider})
                half = half - {1'b0, divider};
            if (half > {1'b0, divider})
                half = '0;
            rx_sample_at = half[7:0];
            rx_st        = RX_START;
        end
        rx_last_level = rx;

        if (wrap)
        begin
            case (tx_st)
                TX_IDLE:
                begin
                    if (!tx_hold_free)
                    begin
                        tx_pin       = 1'b0;
                        tx_shift     = tx_hold;
                        tx_bit       = 3'd0;
                        tx_st        = TX_DATA;
                        tx_hold_free = 1'b1;
                        tx_done      = 1'b0;
                    end
                end
                TX_DATA:
                begin
                    tx_pin   = tx_shift[0];
                    tx_shift = tx_shift >> 1;
                    if (tx_bit == BIT_LAST)
                        tx_st = TX_STOP;
                    else
                        tx_bit = tx_bit + 3'd1;
                end
                TX_STOP:
                begin
                    tx_pin = 1'b1;
                    tx_st  = TX_FINISH;
                end
                default:
                begin
                    tx_done = 1'b1;
                    tx_st   = TX_IDLE;
                end
            endcase
        end
        tick_cnt = wrap ? 8'd0 : t + 8'd1;

        if (wr && tx_hold_free)
        begin
            tx_hold      = tx_data;
            tx_hold_free = 1'b0;
        end

        if (pop && rx_queue.size() > 0)
        begin
            r.rx_byte       = rx_queue.pop_front();
            r.rx_byte_valid = 1'b1;
        end

        if (push)
        begin
            if (rx_queue.size() >= FIFO_DEPTH)
            begin
                r.rx_overflow = 1'b1;
                bytes_dropped++;
            end
            else
            begin
                rx_queue.push_back(push_byte);
                bytes_queued++;
            end
        end

        r.tx_line       = tx_pin;
        r.tx_hold_empty = tx_hold_free;
        r.tx_all_done   = tx_done;
        r.rx_fifo_empty = (rx_queue.size() == 0);
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [7:0] exp_val,
                                 input logic [7:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected %0h, got %0h", field, exp_val, got_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider       = DIVIDER_RESET;
            tick_cnt      = 8'd0;
            tx_st         = TX_IDLE;
            tx_bit        = 3'd0;
            tx_shift      = 8'h00;
            tx_hold       = 8'h00;
            tx_hold_free  = 1'b1;
            tx_done       = 1'b1;
            tx_pin        = 1'b1;
            rx_st         = RX_IDLE;
            rx_bit        = 3'd0;
            rx_shift      = 8'h00;
            rx_sample_at  = 8'h00;
            rx_last_level = 1'b1;
            rx_queue.delete();
            status_due.delete();
            fail_count    = 0;
            pending       = 0;
            bytes_queued  = 0;
            bytes_dropped = 0;
        end
        else
        begin
            if (status.valid && status.ready)
            begin
                seen = {status.tx_line, status.tx_hold_empty, status.tx_all_done,
                        status.rx_byte, status.rx_byte_valid, status.rx_fifo_empty,
                        status.rx_overflow};
                if (status_due.size() == 0)
                begin
                    $error("status request with no tick outstanding");
                    fail_count++;
                end
                else
                begin
                    want = status_due.pop_front();
                    compare_field("tx_line", want.tx_line, seen.tx_line);
                    compare_field("tx_hold_empty", want.tx_hold_empty, seen.tx_hold_empty);
                    compare_field("tx_all_done", want.tx_all_done, seen.tx_all_done);
                    compare_field("rx_byte", want.rx_byte, seen.rx_byte);
                    compare_field("rx_byte_valid", want.rx_byte_valid, seen.rx_byte_valid);
                    compare_field("rx_fifo_empty", want.rx_fifo_empty, seen.rx_fifo_empty);
                    compare_field("rx_overflow", want.rx_overflow, seen.rx_overflow);
                end
            end

            if (tick.valid && tick.ready)
                status_due.push_back(advance_tick(tick.rx_line, tick.tx_write,
                                                  tick.tx_byte, tick.rx_pop));

            // a register write counts from the next tick on
            if (bit_divider_we)
                divider = bit_divider_wdata;

            pending = status_due.size();
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the 8N1 transceiver. Every tick request carries
// one timer tick; serial frames are built on rx_line by holding each bit for
// a full bit period of ticks, so the receiver really locks on and fills its
// queue. Prediction and comparison live in the status checker beside u_top.
module tb;
    import uart_pkg::*;

    localparam int FIFO_DEPTH = 16;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       bit_divider_we;
    logic [7:0] bit_divider_wdata;

    uart_tick_if   tick ();
    uart_status_if status ();

    // bench-side copy of the divider, only for sizing bit periods
    logic [7:0] divider_now = DIVIDER_RESET;
    int         pop_pct     = 0;
    logic       calm        = 1'b0;   // no idling on either side when set
    logic       squeeze_req = 1'b0;   // asks the status side for one long hold-off
    int         ticks_sent     = 0;
    int         statuses_taken = 0;
    int         good_frames    = 0;

    int fail_count;
    int pending;
    int bytes_queued;
    int bytes_dropped;

    uart_8n1_transceiver_rx_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .tick              (tick),
        .status            (status),
        .bit_divider_we    (bit_divider_we),
        .bit_divider_wdata (bit_divider_wdata)
    );

    uart_status_check #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_status_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .tick              (tick),
        .status            (status),
        .bit_divider_we    (bit_divider_we),
        .bit_divider_wdata (bit_divider_wdata),
        .fail_count        (fail_count),
        .pending           (pending),
        .bytes_queued      (bytes_queued),
        .bytes_dropped     (bytes_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop, well beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    // status requests taken so far; nonblocking so the stimulus side reads
    // a stable pre-edge count
    always @(posedge clk)
    begin
        if (rst_n && status.valid && status.ready)
            statuses_taken <= statuses_taken + 1;
    end

    // Status side: random stall bursts, one long hold-off on request so the
    // status register stays full and tick backs up, and none once calm.
    initial
    begin
        bit squeezed;
        squeezed = 1'b0;
        status.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (squeeze_req && !squeezed)
            begin
                status.ready <= 1'b0;
                repeat (300) @(posedge clk);
                squeezed = 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                status.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                status.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one tick request and hold it until taken. Always entered and left
    // on a rising edge; valid stays high across back-to-back requests.
    task automatic send_tick(input logic rx, input logic wr, input logic [7:0] data,
                             input logic pop);
        int gap;
        gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0)
        begin
            tick.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick.valid    <= 1'b1;
        tick.rx_line  <= rx;
        tick.tx_write <= wr;
        tick.tx_byte  <= data;
        tick.rx_pop   <= pop;
        do
            @(posedge clk);
        while (!tick.ready);
        ticks_sent++;
    endtask

    // line level as given, random transmit writes and pops alongside
    task automatic line_tick(input logic level);
        send_tick(level, ($urandom_range(0, 9) == 0), 8'($urandom),
                  ($urandom_range(0, 99) < pop_pct));
    endtask

    task automatic hold_line(input logic level, input int n);
        repeat (n) line_tick(level);
    endtask

    // start bit, data LSB first, stop bit; each bit lasts divider + 1 ticks
    task automatic send_frame(input logic [7:0] data, input logic stop_bit);
        logic [9:0] bits;
        bits = {stop_bit, data, 1'b0};
        for (int i = 0; i < 10; i++)
            hold_line(bits[i], int'(divider_now) + 1);
    endtask

    // mostly clean frames; the rest are short start glitches, frames with a
    // low stop bit, or plain line noise
    task automatic frame_or_noise(input int broken_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick >= broken_pct)
        begin
            send_frame(8'($urandom), 1'b1);
            good_frames++;
        end
        else
        begin
            case (pick % 3)
                0: hold_line(1'b0, $urandom_range(1, int'(divider_now >> 1)));
                1: send_frame(8'($urandom), 1'b0);
                default:
                    repeat ($urandom_range(4, 20)) line_tick(1'($urandom_range(0, 1)));
            endcase
        end
        hold_line(1'b1, $urandom_range(1, int'(divider_now) + 2));
    endtask

    // drop valid and wait until every tick has its status back
    task automatic settle();
        tick.valid <= 1'b0;
        while (statuses_taken != ticks_sent)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_divider(input logic [7:0] value);
        bit_divider_we    <= 1'b1;
        bit_divider_wdata <= value;
        divider_now = value;
        @(posedge clk);
        bit_divider_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] div, input int frames, input int pops,
                             input int broken_pct);
        settle();
        set_divider(div);
        pop_pct = pops;
        repeat (frames) frame_or_noise(broken_pct);
    endtask

    initial
    begin
        tick.valid        <= 1'b0;
        tick.rx_line      <= 1'b1;
        tick.tx_write     <= 1'b0;
        tick.tx_byte      <= 8'h00;
        tick.rx_pop       <= 1'b0;
        bit_divider_we    <= 1'b0;
        bit_divider_wdata <= 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset divider, pop on an empty queue, load 0xFF, a second
        // write while the holding register is full, then a falling edge that
        // schedules its sample well past the divider about to be set
        send_tick(1'b1, 1'b0, 8'h00, 1'b1);
        send_tick(1'b1, 1'b1, 8'hFF, 1'b0);
        send_tick(1'b1, 1'b1, 8'h00, 1'b1);
        send_tick(1'b0, 1'b0, 8'h5A, 1'b0);
        send_tick(1'b0, 1'b1, 8'hA5, 1'b1);
        send_tick(1'b1, 1'b0, 8'h00, 1'b0);
        settle();
        // count now above the new divider; sample point out of range, so the
        // start bit is checked on the wrap tick and seen high
        set_divider(8'd2);
        send_tick(1'b1, 1'b0, 8'h3C, 1'b1);
        send_tick(1'b0, 1'b0, 8'hC3, 1'b0);
        send_tick(1'b1, 1'b0, 8'h00, 1'b1);
        send_tick(1'b1, 1'b1, 8'h00, 1'b0);

        // smallest divider, no pops, one long status hold-off early on:
        // extreme bytes first, then enough clean frames to fill the queue
        // and drop one
        settle();
        squeeze_req <= 1'b1;
        set_divider(8'd2);
        pop_pct = 0;
        send_frame(8'h00, 1'b1);
        hold_line(1'b1, 2);
        send_frame(8'hFF, 1'b1);
        hold_line(1'b1, 2);
        good_frames += 2;
        repeat (15) frame_or_noise(0);

        // largest divider: start a frame, then lower the divider mid-start so
        // the sample point lies beyond it
        settle();
        set_divider(8'd255);
        hold_line(1'b1, $urandom_range(1, 8));
        hold_line(1'b0, 4);
        settle();
        set_divider(8'd2);
        repeat (4) hold_line(1'($urandom_range(0, 1)), 3);
        hold_line(1'b1, 6);

        // count left high under 255, then a falling edge on the first tick at
        // divider 3: the half-bit sum stays above the divider and clamps to 0
        settle();
        set_divider(8'd255);
        hold_line(1'b1, $urandom_range(8, 20));
        settle();
        set_divider(8'd3);
        send_frame(8'($urandom), 1'b1);
        good_frames++;
        hold_line(1'b1, 4);

        // last stretch runs flat out on both sides: a frame with a low stop
        // bit, then frequent pops drain the queue
        settle();
        calm <= 1'b1;
        set_divider(8'd2);
        pop_pct = 60;
        send_frame(8'($urandom), 1'b0);
        hold_line(1'b1, 3);
        run_phase(8'd3, 1, 60, 0);

        settle();
        repeat (5) @(posedge clk);
        if (pending != 0)
            $error("%0d status requests never arrived", pending);

        $display("Covered %0d tick requests at dividers 2 to 255, %0d clean frames sent,",
                 ticks_sent, good_frames);
        $display("%0d bytes queued, %0d dropped on a full queue.", bytes_queued, bytes_dropped);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
